// ===== design/srms_pkg.sv =====
package srms_pkg;

  // Default width of one line-sensor sample
  localparam int unsigned SENSOR_BITS_DEF = 12;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned THR_W      = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_THRESHOLD   = 3'd0,
    CFG_STOPS_PER_AXIS   = 3'd1,
    CFG_STOP_WAIT_MS     = 3'd2,
    CFG_FOLLOW_SETTLE_MS = 3'd3,
    CFG_RETURN_SETTLE_MS = 3'd4,
    CFG_RETURN_SPEED     = 3'd5,
    CFG_NORMAL_SPEED     = 3'd6
  } cfg_idx_e;

  // Register reset values
  localparam logic [THR_W-1:0] LINE_THRESHOLD_RST   = 12'd2048;
  localparam logic [7:0]       STOPS_PER_AXIS_RST   = 8'd4;
  localparam logic [31:0]      STOP_WAIT_MS_RST     = 32'd120000;
  localparam logic [31:0]      FOLLOW_SETTLE_MS_RST = 32'd1750;
  localparam logic [31:0]      RETURN_SETTLE_MS_RST = 32'd2500;
  localparam logic [7:0]       RETURN_SPEED_RST     = 8'd100;
  localparam logic [7:0]       NORMAL_SPEED_RST     = 8'd50;

  localparam logic [7:0] STOP_COUNT_MAX = 8'd255;

  // Mode codes as seen on the result channel
  typedef enum logic [2:0] {
    MODE_CALIBRATE = 3'd0,
    MODE_WAIT      = 3'd1,
    MODE_FOLLOW    = 3'd2,
    MODE_STOP      = 3'd3,
    MODE_CONFIRM   = 3'd4,
    MODE_RETURN    = 3'd5
  } mode_code_e;

  // Sequencer state, one-hot
  typedef enum logic [5:0] {
    ST_CALIBRATE = 6'b000001,
    ST_WAIT      = 6'b000010,
    ST_FOLLOW    = 6'b000100,
    ST_STOP      = 6'b001000,
    ST_CONFIRM   = 6'b010000,
    ST_RETURN    = 6'b100000
  } state_e;

  // Event codes
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_CALIBRATED = 3'd1,
    EV_STOP_LINE  = 3'd2,
    EV_WAIT_OVER  = 3'd3,
    EV_ORIGIN     = 3'd4
  } event_e;

  // One result transaction
  typedef struct packed {
    mode_code_e mode;
    logic       motors_on;
    logic       follow_now;
    logic       calibrate_now;
    logic       brake_now;
    logic       zero_drive;
    logic [7:0] stops_seen;
    logic [7:0] speed_cap;
    event_e     event_res;
  } res_t;

  function automatic mode_code_e mode_code(input state_e st);
    mode_code_e m;
    case (st)
      ST_CALIBRATE: m = MODE_CALIBRATE;
      ST_WAIT:      m = MODE_WAIT;
      ST_FOLLOW:    m = MODE_FOLLOW;
      ST_STOP:      m = MODE_STOP;
      ST_CONFIRM:   m = MODE_CONFIRM;
      ST_RETURN:    m = MODE_RETURN;
      default:      m = MODE_STOP;
    endcase
    return m;
  endfunction

endpackage

// ===== design/srms_if.sv =====
// Input channel: one control tick
interface srms_in_if
  import srms_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = SENSOR_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [31:0]            now_ms;
  logic                   cal_pressed;
  logic                   start_pressed;
  logic [SENSOR_BITS-1:0] sensor_one;
  logic [SENSOR_BITS-1:0] sensor_two;
  logic [SENSOR_BITS-1:0] sensor_three;
  logic [SENSOR_BITS-1:0] sensor_four;
  logic [SENSOR_BITS-1:0] sensor_five;

  modport source (
    output valid, now_ms, cal_pressed, start_pressed,
           sensor_one, sensor_two, sensor_three, sensor_four, sensor_five,
    input  ready
  );
  modport sink (
    input  valid, now_ms, cal_pressed, start_pressed,
           sensor_one, sensor_two, sensor_three, sensor_four, sensor_five,
    output ready
  );
endinterface

// Result channel: one result per tick
interface srms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       motors_on;
  logic       follow_now;
  logic       calibrate_now;
  logic       brake_now;
  logic       zero_drive;
  logic [7:0] stops_seen;
  logic [7:0] speed_cap;
  logic [2:0] event_res;

  modport source (
    output valid, mode, motors_on, follow_now, calibrate_now, brake_now,
           zero_drive, stops_seen, speed_cap, event_res,
    input  ready
  );
  modport sink (
    input  valid, mode, motors_on, follow_now, calibrate_now, brake_now,
           zero_drive, stops_seen, speed_cap, event_res,
    output ready
  );
endinterface

// ===== design/survey_robot_mode_sequencer_unit.sv =====
// Channel   | Dir | Handshake   | Carries
// ----------+-----+-------------+-------------------------------------------
// in_i      | in  | valid/ready | now_ms, buttons, five sensor samples
// res_o     | out | valid/ready | mode, flags, stop count, speed cap, event
// cfg_*     | in  | write enable| register index, 32-bit write data
//
// An input transaction passes through one input register, then the mode
// update goes straight into the result register.
// One tick is accepted every cycle while the result is not stalled; the
// throughput is set by the single state update between the input and result registers.
// A stalled result holds both stages; the input register refills as soon
// as its tick moves on. Reset clears state and restores register defaults.
module survey_robot_mode_sequencer_unit
  import srms_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = SENSOR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srms_in_if.sink               in_i,
  srms_out_if.source            res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CMP_W = (SENSOR_BITS > THR_W) ? SENSOR_BITS : THR_W;
  localparam int unsigned N_SENS = 5;

  // Configuration registers
  logic [THR_W-1:0] line_threshold_q;
  logic [7:0]       stops_per_axis_q;
  logic [31:0]      stop_wait_ms_q;
  logic [31:0]      follow_settle_ms_q;
  logic [31:0]      return_settle_ms_q;
  logic [7:0]       return_speed_q;
  logic [7:0]       normal_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_threshold_q   <= LINE_THRESHOLD_RST;
      stops_per_axis_q   <= STOPS_PER_AXIS_RST;
      stop_wait_ms_q     <= STOP_WAIT_MS_RST;
      follow_settle_ms_q <= FOLLOW_SETTLE_MS_RST;
      return_settle_ms_q <= RETURN_SETTLE_MS_RST;
      return_speed_q     <= RETURN_SPEED_RST;
      normal_speed_q     <= NORMAL_SPEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_THRESHOLD:   line_threshold_q   <= cfg_wdata_i[THR_W-1:0];
        CFG_STOPS_PER_AXIS:   stops_per_axis_q   <= cfg_wdata_i[7:0];
        CFG_STOP_WAIT_MS:     stop_wait_ms_q     <= cfg_wdata_i;
        CFG_FOLLOW_SETTLE_MS: follow_settle_ms_q <= cfg_wdata_i;
        CFG_RETURN_SETTLE_MS: return_settle_ms_q <= cfg_wdata_i;
        CFG_RETURN_SPEED:     return_speed_q     <= cfg_wdata_i[7:0];
        CFG_NORMAL_SPEED:     normal_speed_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic in_valid_q;
  logic res_valid_q;
  logic advance;
  logic in_take;

  assign advance    = in_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) res_valid_q <= 1'b1;
      else if (res_o.ready) res_valid_q <= 1'b0;
    end
  end

  // Input register
  logic [31:0]            now_q;
  logic                   cal_q;
  logic                   start_q;
  logic [SENSOR_BITS-1:0] sens_q [N_SENS];

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q     <= in_i.now_ms;
      cal_q     <= in_i.cal_pressed;
      start_q   <= in_i.start_pressed;
      sens_q[0] <= in_i.sensor_one;
      sens_q[1] <= in_i.sensor_two;
      sens_q[2] <= in_i.sensor_three;
      sens_q[3] <= in_i.sensor_four;
      sens_q[4] <= in_i.sensor_five;
    end
  end

  // Line detect: any sensor below threshold
  logic line_seen;
  always_comb begin
    line_seen = 1'b0;
    for (int i = 0; i < N_SENS; i++) begin
      if (CMP_W'(sens_q[i]) < CMP_W'(line_threshold_q)) line_seen = 1'b1;
    end
  end

  // Sequencer state
  state_e      state_q, state_d;
  logic [31:0] wait_start_q, wait_start_d;
  logic [7:0]  stop_cnt_q, stop_cnt_d;
  logic        motor_en_q, motor_en_d;
  logic [7:0]  speed_q, speed_d;

  logic [31:0] elapsed;
  logic        follow_ok, return_ok, wait_over, axis_end;
  logic        follow_f, calib_f, brake_f, zero_f;
  event_e      ev;

  assign elapsed   = now_q - wait_start_q;
  assign follow_ok = line_seen && (elapsed >= follow_settle_ms_q);
  assign return_ok = line_seen && (elapsed >= return_settle_ms_q);
  assign wait_over = elapsed >= stop_wait_ms_q;
  assign axis_end  = stop_cnt_q == stops_per_axis_q;

  // Next-state logic for one tick
  always_comb begin
    state_d      = state_q;
    wait_start_d = wait_start_q;
    stop_cnt_d   = stop_cnt_q;
    motor_en_d   = motor_en_q;
    speed_d      = speed_q;
    follow_f     = 1'b0;
    calib_f      = 1'b0;
    brake_f      = 1'b0;
    zero_f       = 1'b0;
    ev           = EV_NONE;
    case (state_q)
      ST_CALIBRATE: begin
        if (cal_q) begin
          calib_f    = 1'b1;
          motor_en_d = 1'b1;
          state_d    = ST_WAIT;
          ev         = EV_CALIBRATED;
        end else if (start_q) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (start_q) begin
          motor_en_d   = 1'b1;
          state_d      = ST_FOLLOW;
          wait_start_d = now_q;
        end
      end
      ST_FOLLOW: begin
        follow_f = 1'b1;
        if (cal_q) begin
          state_d = ST_CALIBRATE;
          zero_f  = 1'b1;
        end
        // a line in the same tick overrides recalibration
        if (follow_ok) begin
          brake_f      = 1'b1;
          motor_en_d   = 1'b0;
          if (stop_cnt_q != STOP_COUNT_MAX) stop_cnt_d = stop_cnt_q + 8'd1;
          state_d      = ST_STOP;
          wait_start_d = now_q;
          ev           = EV_STOP_LINE;
        end
      end
      ST_STOP: begin
        motor_en_d = 1'b0;
        if (axis_end) begin
          state_d      = ST_RETURN;
          wait_start_d = now_q;
          motor_en_d   = 1'b1;
          stop_cnt_d   = '0;
          if (!cal_q && wait_over) ev = EV_WAIT_OVER;
        end else if (wait_over) begin
          state_d      = ST_CONFIRM;
          wait_start_d = '0;
          ev           = EV_WAIT_OVER;
        end else if (cal_q) begin
          state_d = ST_CONFIRM;
        end
      end
      ST_CONFIRM: begin
        if (start_q && !cal_q) begin
          motor_en_d   = 1'b1;
          state_d      = ST_FOLLOW;
          wait_start_d = now_q;
        end
      end
      ST_RETURN: begin
        follow_f = 1'b1;
        speed_d  = return_speed_q;
        if (return_ok) begin
          brake_f    = 1'b1;
          motor_en_d = 1'b0;
          speed_d    = normal_speed_q;
          state_d    = ST_WAIT;
          ev         = EV_ORIGIN;
        end
      end
      default: state_d = ST_STOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CALIBRATE;
      wait_start_q <= '0;
      stop_cnt_q   <= '0;
      motor_en_q   <= 1'b0;
      speed_q      <= NORMAL_SPEED_RST;
    end else if (advance) begin
      state_q      <= state_d;
      wait_start_q <= wait_start_d;
      stop_cnt_q   <= stop_cnt_d;
      motor_en_q   <= motor_en_d;
      speed_q      <= speed_d;
    end
  end

  // Result register
  res_t res_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.mode          <= mode_code(state_d);
      res_q.motors_on     <= motor_en_d;
      res_q.follow_now    <= follow_f;
      res_q.calibrate_now <= calib_f;
      res_q.brake_now     <= brake_f;
      res_q.zero_drive    <= zero_f;
      res_q.stops_seen    <= stop_cnt_d;
      res_q.speed_cap     <= speed_d;
      res_q.event_res     <= ev;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.mode          = res_q.mode;
  assign res_o.motors_on     = res_q.motors_on;
  assign res_o.follow_now    = res_q.follow_now;
  assign res_o.calibrate_now = res_q.calibrate_now;
  assign res_o.brake_now     = res_q.brake_now;
  assign res_o.zero_drive    = res_q.zero_drive;
  assign res_o.stops_seen    = res_q.stops_seen;
  assign res_o.speed_cap     = res_q.speed_cap;
  assign res_o.event_res     = res_q.event_res;

  // Checks
  a_brake_motors_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.brake_now |-> !res_q.motors_on)
    else $error("brake pulse with motors enabled");

  a_stop_event_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.event_res == EV_STOP_LINE) |->
      (res_q.mode == MODE_STOP) && res_q.brake_now)
    else $error("stop line event without stop wait and brake");

  a_zero_in_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.zero_drive |-> res_q.follow_now)
    else $error("zero drive outside follow mode");

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted tick lost from input register");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_o.ready && !advance |=> !res_valid_q)
    else $error("result repeated after transaction");

endmodule
